### src/mhpq_pkg.sv
package mhpq_pkg;

    localparam int DEPTH_DEF    = 1024;
    localparam int KEY_BITS_DEF = 32;
    localparam int ID_BITS_DEF  = 16;

    localparam int KEY_W = 32;
    localparam int ID_W  = 16;
    localparam int POS_W = 11;
    localparam int CAP_W = 11;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_EXTRACT = 2'd1;
    localparam logic [1:0] OP_CHANGE  = 2'd2;
    localparam logic [1:0] OP_PEEK    = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_BAD_POS = 2'd3;

    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
        logic [POS_W-1:0] pos;
    } t_cmd;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
        logic [1:0]       status;
        logic [POS_W-1:0] count;
    } t_result;

endpackage

### src/mhpq_mem.sv
module mhpq_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### src/mhpq_ctrl.sv
module mhpq_ctrl #(
    parameter int DEPTH    = 1024,
    parameter int KEY_BITS = 32,
    parameter int ID_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cmd_valid,
    output logic                              o_cmd_ready,
    input  mhpq_pkg::t_cmd                    i_cmd,
    input  logic [mhpq_pkg::CAP_W-1:0]        i_cap,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output mhpq_pkg::t_result                 o_res,
    output logic                              o_we,
    output logic [$clog2(DEPTH)-1:0]          o_waddr,
    output logic [KEY_BITS+ID_BITS-1:0]       o_wdata,
    output logic [$clog2(DEPTH)-1:0]          o_raddr_a,
    output logic [$clog2(DEPTH)-1:0]          o_raddr_b,
    input  logic [KEY_BITS+ID_BITS-1:0]       i_rdata_a,
    input  logic [KEY_BITS+ID_BITS-1:0]       i_rdata_b
);

    import mhpq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = KEY_BITS + ID_BITS;
    localparam int WW = (CW > CAP_W) ? CW : CAP_W;
    localparam int KX = (KEY_BITS > KEY_W) ? KEY_BITS : KEY_W;
    localparam int IX = (ID_BITS > ID_W) ? ID_BITS : ID_W;

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ROOT    = CW'(1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_UPI  = 3'd2;
    localparam logic [2:0] S_UP   = 3'd3;
    localparam logic [2:0] S_DNI  = 3'd4;
    localparam logic [2:0] S_DN   = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    function automatic logic [AW-1:0] addr_of(input logic [CW:0] p);
        logic [CW:0] t;
        t = p - 1'b1;
        return t[AW-1:0];
    endfunction

    function automatic logic less(input logic [EW-1:0] a, input logic [EW-1:0] b);
        return $signed(a[EW-1:ID_BITS]) < $signed(b[EW-1:ID_BITS]);
    endfunction

    logic [2:0]          r_state, n_state;
    logic [1:0]          r_op, n_op;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_hole, n_hole;
    logic [EW-1:0]       r_carry, n_carry;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [KEY_W-1:0]    r_res_key, n_res_key;
    logic [ID_W-1:0]     r_res_id, n_res_id;
    logic [1:0]          r_status, n_status;

    logic [KX-1:0]       key_x;
    logic [KEY_BITS-1:0] key_in;
    logic [IX-1:0]       id_x;
    logic [ID_BITS-1:0]  id_in;
    logic [KX-1:0]       rkey_x;
    logic [IX-1:0]       rid_x;
    logic [WW-1:0]       pos_w, cnt_w, cap_w;
    logic [CW-1:0]       pos_c;
    logic                full, bad_pos;
    logic [CW:0]         lpos, rpos, cnt_x;
    logic                has_l, has_r, take_l, take_r;
    logic [EW-1:0]       best_l;

    assign key_x  = KX'($signed(i_cmd.key));
    assign key_in = key_x[KEY_BITS-1:0];
    assign id_x   = IX'(i_cmd.id);
    assign id_in  = id_x[ID_BITS-1:0];
    assign rkey_x = KX'($signed(i_rdata_a[EW-1:ID_BITS]));
    assign rid_x  = IX'(i_rdata_a[ID_BITS-1:0]);

    assign pos_w   = WW'(i_cmd.pos);
    assign cnt_w   = WW'(r_count);
    assign cap_w   = WW'(i_cap);
    assign pos_c   = pos_w[CW-1:0];
    assign full    = (cnt_w >= cap_w) || (r_count == DEPTH_C);
    assign bad_pos = (pos_w == '0) || (pos_w > cnt_w);

    assign lpos   = {r_hole, 1'b0};
    assign rpos   = {r_hole, 1'b1};
    assign cnt_x  = {1'b0, r_count};
    assign has_l  = lpos <= cnt_x;
    assign has_r  = rpos <= cnt_x;
    assign take_l = has_l && less(i_rdata_a, r_carry);
    assign best_l = take_l ? i_rdata_a : r_carry;
    assign take_r = has_r && less(i_rdata_b, best_l);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_count   = r_count;
        n_hole    = r_hole;
        n_carry   = r_carry;
        n_key     = r_key;
        n_res_key = r_res_key;
        n_res_id  = r_res_id;
        n_status  = r_status;
        o_we      = 1'b0;
        o_waddr   = addr_of({1'b0, r_hole});
        o_wdata   = r_carry;
        o_raddr_a = addr_of({1'b0, ROOT});
        o_raddr_b = addr_of({1'b0, r_count});

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_op      = i_cmd.op;
                    n_key     = key_in;
                    n_res_key = '0;
                    n_res_id  = '0;
                    n_status  = ST_OK;
                    unique case (i_cmd.op) inside
                        OP_INSERT: begin
                            if (full) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_count = r_count + 1'b1;
                                n_hole  = r_count + 1'b1;
                                n_carry = {key_in, id_in};
                                n_state = S_UPI;
                            end
                        end
                        OP_EXTRACT, OP_PEEK: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        default: begin
                            if (bad_pos) begin
                                n_status = ST_BAD_POS;
                                n_state  = S_DONE;
                            end else begin
                                o_raddr_a = addr_of({1'b0, pos_c});
                                n_hole    = pos_c;
                                n_state   = S_RD;
                            end
                        end
                    endcase
                end
            end
            S_RD: begin
                if (r_op == OP_CHANGE) begin
                    n_carry = {r_key, i_rdata_a[ID_BITS-1:0]};
                    if ($signed(r_key) < $signed(i_rdata_a[EW-1:ID_BITS])) begin
                        n_state = S_UPI;
                    end else begin
                        n_state = S_DNI;
                    end
                end else begin
                    n_res_key = rkey_x[KEY_W-1:0];
                    n_res_id  = rid_x[ID_W-1:0];
                    if (r_op == OP_EXTRACT) begin
                        n_carry = i_rdata_b;
                        n_count = r_count - 1'b1;
                        n_hole  = ROOT;
                        n_state = (r_count == ROOT) ? S_DONE : S_DNI;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_UPI: begin
                if (r_hole == ROOT) begin
                    o_we    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_raddr_a = addr_of({2'b00, r_hole[CW-1:1]});
                    n_state   = S_UP;
                end
            end
            S_UP: begin
                o_we = 1'b1;
                if (less(r_carry, i_rdata_a)) begin
                    o_wdata = i_rdata_a;
                    n_hole  = {1'b0, r_hole[CW-1:1]};
                    n_state = S_UPI;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DNI: begin
                if (!has_l) begin
                    o_we    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_raddr_a = addr_of(lpos);
                    o_raddr_b = addr_of(rpos);
                    n_state   = S_DN;
                end
            end
            S_DN: begin
                o_we = 1'b1;
                if (take_r) begin
                    o_wdata = i_rdata_b;
                    n_hole  = rpos[CW-1:0];
                    n_state = S_DNI;
                end else if (take_l) begin
                    o_wdata = i_rdata_a;
                    n_hole  = lpos[CW-1:0];
                    n_state = S_DNI;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_hole    <= n_hole;
        r_carry   <= n_carry;
        r_key     <= n_key;
        r_res_key <= n_res_key;
        r_res_id  <= n_res_id;
        r_status  <= n_status;
    end

    assign o_cmd_ready  = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res.key    = r_res_key;
    assign o_res.id     = r_res_id;
    assign o_res.status = r_status;
    assign o_res.count  = cnt_w[POS_W-1:0];

endmodule

### src/min_heap_priority_queue_top.sv
// channel   dir  signals                          beat contents
// s_axis    in   tvalid tready tdata[63:0] tuser  one heap operation
// m_axis    out  tvalid tready tdata[63:0] tuser  one result per operation
// cfg       in   i_cfg_valid o_cfg_ready data     capacity limit, always ready
//
// between accept and result an operation walks the heap level by level;
// each level is one read of the single heap memory (both children at once on
// the way down) and one write back
// synchronous reset clears the entry count and sets the capacity limit to 1024
// the result sits in an output register; a stalled m_axis holds the next
// result inside the controller and keeps s_axis tready low
module min_heap_priority_queue_top #(
    parameter int DEPTH    = mhpq_pkg::DEPTH_DEF,
    parameter int KEY_BITS = mhpq_pkg::KEY_BITS_DEF,
    parameter int ID_BITS  = mhpq_pkg::ID_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [63:0]                 s_axis_tdata,  // key_value, entry_id, entry_position
    input  logic [1:0]                  s_axis_tuser,  // operation
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [63:0]                 m_axis_tdata,  // result_key, result_id, entry_count
    output logic [1:0]                  m_axis_tuser,  // status
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mhpq_pkg::CAP_W-1:0]  i_cfg_data
);

    import mhpq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int EW = KEY_BITS + ID_BITS;

    logic [CAP_W-1:0] r_cap;
    logic             r_m_valid;
    t_result          r_m_res;

    t_cmd             cmd;
    t_result          res;
    logic             res_valid, res_ready;
    logic             we;
    logic [AW-1:0]    waddr, raddr_a, raddr_b;
    logic [EW-1:0]    wdata, rdata_a, rdata_b;

    assign cmd.op  = s_axis_tuser;
    assign cmd.key = s_axis_tdata[31:0];
    assign cmd.id  = s_axis_tdata[47:32];
    assign cmd.pos = s_axis_tdata[58:48];

    assign o_cfg_ready = 1'b1;
    assign res_ready   = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= CAP_RESET;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (res_valid && res_ready) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_m_res <= res;
        end
    end

    mhpq_ctrl #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS),
        .ID_BITS  (ID_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (s_axis_tvalid),
        .o_cmd_ready (s_axis_tready),
        .i_cmd       (cmd),
        .i_cap       (r_cap),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr_a   (raddr_a),
        .o_raddr_b   (raddr_b),
        .i_rdata_a   (rdata_a),
        .i_rdata_b   (rdata_b)
    );

    mhpq_mem #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {5'b0, r_m_res.count, r_m_res.id, r_m_res.key};
    assign m_axis_tuser  = r_m_res.status;

endmodule
